### design/speed_pi_window_control_defines.svh
// assertion macros for the speed pi window control checker
// no dependencies; included by the checker file only
`ifndef SPEED_PI_WINDOW_CONTROL_DEFINES_SVH
`define SPEED_PI_WINDOW_CONTROL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SPWC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SPWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/spwc_pkg.sv
// shared types, widths and constants of the speed pi window control block
// no dependencies; imported by every module of the block
package spwc_pkg;

	// field widths
	localparam int SPEED_W = 12;
	localparam int ERR_W   = 13;
	localparam int FILT_W  = 24;
	localparam int OUTV_W  = 40;
	localparam int GAIN_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int DRIVE_W = 11;

	// default sizes
	localparam int WINDOW_LEN_DEF   = 20;
	localparam int SMOOTH_STEPS_DEF = 10;

	// fixed point constants
	localparam int FILT_TAKE   = 154;
	localparam int FILT_KEEP   = 870;
	localparam int FILT_SHIFT  = 10;
	localparam int ERR_SHIFT   = 11;
	localparam int DRIVE_LIMIT = 600;
	localparam int DRIVE_SCALE = 256;

	// shared multiplier and divider sizes
	localparam int MUL_A_W = OUTV_W;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int QUO_W   = $clog2(DRIVE_LIMIT + 1);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = GAIN_W;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = CFG_IDX_W'(1);
	localparam logic [GAIN_W-1:0]    PROP_GAIN_RST     = GAIN_W'(256);
	localparam logic [GAIN_W-1:0]    INTEGRAL_GAIN_RST = GAIN_W'(0);

	// operation codes
	localparam logic OP_CONTROL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// magnitude width of an unclipped smoothed value
	function automatic int mag_width(input int steps);
		return $clog2(DRIVE_LIMIT * steps * DRIVE_SCALE + 1);
	endfunction

	typedef struct packed {
		logic                      operation;
		logic signed [SPEED_W-1:0] measured_speed;
		logic signed [SPEED_W-1:0] target_speed;
		logic                      clear_history;
		logic [SLOT_W-1:0]         slot_index;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      saturated;
	} out_item_t;

	// multiply-accumulate command
	typedef struct packed {
		logic issue;
		logic first;
	} mac_cmd_t;

	// error window command
	typedef struct packed {
		logic upd;
		logic clr;
	} ring_cmd_t;

endpackage

### design/spwc_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
// depends on spwc_pkg
module spwc_mac import spwc_pkg::*; #(
	parameter int ACC_W = OUTV_W + 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mac_cmd_t                  cmd,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [ACC_W-1:0]   acc
);

	logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;
	logic signed [ACC_W-1:0]           prod_s1;
	logic                              issue_s1;
	logic                              first_s1;
	logic signed [ACC_W-1:0]           acc_q;

	assign prod_full = a * b;
	assign acc       = acc_q;

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[ACC_W-1:0];
	end

	// accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			first_s1 <= 1'b0;
			acc_q    <= '0;
		end else begin
			issue_s1 <= cmd.issue;
			first_s1 <= cmd.first;
			if (issue_s1) begin
				acc_q <= (first_s1 ? ACC_W'(0) : acc_q) + prod_s1;
			end
		end
	end

endmodule

### design/spwc_ring.sv
// error window: ring memory of recent errors with valid bits and running sum
// depends on spwc_pkg
module spwc_ring import spwc_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	localparam int PTR_W = $clog2(WINDOW_LEN),
	localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ring_cmd_t               cmd,
	input  logic signed [ERR_W-1:0] err,
	output logic signed [SUM_W-1:0] sum
);

	logic [ERR_W-1:0]        ring_mem_q [WINDOW_LEN];
	logic signed [ERR_W-1:0] rd_q;
	logic [WINDOW_LEN-1:0]   valid_q;
	logic [PTR_W-1:0]        ptr_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ERR_W-1:0] oldest;
	logic signed [SUM_W-1:0] base;
	logic [WINDOW_LEN-1:0]   slot_bit;

	assign sum = sum_q;

	// entry leaving the window reads as zero when never written or cleared
	assign oldest   = (valid_q[ptr_q] && !cmd.clr) ? rd_q : ERR_W'(0);
	assign base     = cmd.clr ? SUM_W'(0) : sum_q;
	assign slot_bit = WINDOW_LEN'(1) << ptr_q;

	// ring memory, registered read at the write pointer
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			ring_mem_q[ptr_q] <= err;
		end
		rd_q <= ring_mem_q[ptr_q];
	end

	// pointer, valid bits and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
			sum_q   <= '0;
		end else if (cmd.upd) begin
			valid_q <= (cmd.clr ? WINDOW_LEN'(0) : valid_q) | slot_bit;
			sum_q   <= base - SUM_W'(oldest) + SUM_W'(err);
			ptr_q   <= (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? PTR_W'(0) : ptr_q + PTR_W'(1);
		end
	end

endmodule

### design/spwc_div.sv
// divider by the constant smoothing scale: drop the drive scale, then multiply by a reciprocal
// depends on spwc_pkg
module spwc_div import spwc_pkg::*; #(
	parameter int SMOOTH_STEPS = SMOOTH_STEPS_DEF,
	localparam int MAG_W = mag_width(SMOOTH_STEPS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	// floor(x / S) == (x * ceil(2^(X_W+L) / S)) >> (X_W+L) for every x below 2^X_W
	localparam int SCALE_SH = $clog2(DRIVE_SCALE);
	localparam int X_W      = MAG_W - SCALE_SH;
	localparam int RCP_SH   = X_W + $clog2(SMOOTH_STEPS);
	localparam int RCP_W    = X_W + 1;
	localparam int PROD_W   = X_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((1 << RCP_SH) + SMOOTH_STEPS - 1) / SMOOTH_STEPS);

	logic [X_W-1:0]    x_q;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo_q;
	logic              busy_q;
	logic              done_q;

	assign prod     = PROD_W'(x_q) * PROD_W'(RCP);
	assign done     = done_q;
	assign quotient = quo_q;

	// datapath: magnitude with the drive scale shifted out, then reciprocal product
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend[MAG_W-1:SCALE_SH];
		end
		if (busy_q) begin
			quo_q <= prod[RCP_SH +: QUO_W];
		end
	end

	// busy for one cycle, then a done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

endmodule

### design/speed_pi_window_control.sv
// Control step: taken, then filter, error, window update and controller output states; the next item follows them.
// Smoothing tick: interpolation on the shared multiply-accumulate unit, then the reciprocal divider
// (skipped when clipped), then the result is registered once the output is free; the next item is
// taken after that.
// One item at a time; a waiting result does not block the next item.
// Asynchronous active-low reset: gains 1.0 and 0, filter, error window and outputs zero.
module speed_pi_window_control import spwc_pkg::*; #(
	parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
	parameter int SMOOTH_STEPS = SMOOTH_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ACC_W  = OUTV_W + $clog2(SMOOTH_STEPS) + 1;
	localparam int SUM_W  = ERR_W + $clog2(WINDOW_LEN);
	localparam int MAG_W  = mag_width(SMOOTH_STEPS);
	localparam int KC_W   = SLOT_W + 1;
	localparam int DIFF_W = FILT_W + 2;
	localparam int EF_W   = DIFF_W - ERR_SHIFT;
	localparam int FILT_ROUND = 1 << (FILT_SHIFT - 1);
	localparam int ERR_ROUND  = 1 << (ERR_SHIFT - 1);
	localparam logic signed [EF_W-1:0]    EF_MAX = EF_W'((1 << (ERR_W - 1)) - 1);
	localparam logic signed [EF_W-1:0]    EF_MIN = -EF_W'(1 << (ERR_W - 1));
	localparam logic signed [ACC_W-1:0]   LIM    =
		ACC_W'(DRIVE_LIMIT * SMOOTH_STEPS * DRIVE_SCALE);
	localparam logic signed [DRIVE_W-1:0] DRV_LIM = DRIVE_W'(DRIVE_LIMIT);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILT_A,
		ST_FILT_B,
		ST_FILT_W,
		ST_FILT_DONE,
		ST_ERR,
		ST_RING,
		ST_OUT_B,
		ST_OUT_W,
		ST_OUT_DONE,
		ST_TICK_A,
		ST_TICK_B,
		ST_TICK_W,
		ST_TICK_DONE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	in_item_t                  item_q;
	logic [GAIN_W-1:0]         prop_q;
	logic [GAIN_W-1:0]         igain_q;
	logic signed [FILT_W-1:0]  filt_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [OUTV_W-1:0]  new_q;
	logic signed [OUTV_W-1:0]  old_q;
	logic                      over_q;
	logic                      under_q;
	logic                      neg_q;
	out_item_t                 out_q;
	logic                      out_vld_q;

	mac_cmd_t                  mac_cmd;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [ACC_W-1:0]   acc;
	ring_cmd_t                 ring_cmd;
	logic signed [SUM_W-1:0]   ring_sum;
	logic                      div_start;
	logic                      div_done;
	logic [QUO_W-1:0]          quo;

	logic [KC_W-1:0]                   kc;
	logic [KC_W-1:0]                   coef_new;
	logic [KC_W-1:0]                   coef_old;
	logic signed [ACC_W-1:0]           filt_round;
	logic signed [FILT_W-1:0]          filt_next;
	logic signed [SPEED_W+ERR_SHIFT-1:0] meas_scaled;
	logic signed [SPEED_W+ERR_SHIFT-1:0] targ_scaled;
	logic signed [DIFF_W-1:0]          diff;
	logic signed [EF_W-1:0]            e_full;
	logic signed [ERR_W-1:0]           err_next;
	logic                              v_over;
	logic                              v_under;
	logic signed [ACC_W-1:0]           v_abs;
	logic signed [DRIVE_W-1:0]         quo_ext;
	logic signed [DRIVE_W-1:0]         drive_next;
	logic                              out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= PROP_GAIN_RST;
			igain_q <= INTEGRAL_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:     prop_q  <= cfg_data;
				CFG_INTEGRAL_GAIN: igain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// smoothing slot, clamped to the last slot
	assign kc = ({1'b0, item_q.slot_index} >= KC_W'(SMOOTH_STEPS)) ?
		KC_W'(SMOOTH_STEPS - 1) : {1'b0, item_q.slot_index};
	assign coef_new = kc + KC_W'(1);
	assign coef_old = KC_W'(SMOOTH_STEPS - 1) - kc;

	// target filter: round and drop the fraction scale of the keep ratio
	assign filt_round = acc + ACC_W'(FILT_ROUND);
	assign filt_next  = filt_round[FILT_SHIFT +: FILT_W];

	// speed error, nearest integer, clipped to the error width
	assign meas_scaled = $signed({item_q.measured_speed, {ERR_SHIFT{1'b0}}});
	assign targ_scaled = $signed({item_q.target_speed, {ERR_SHIFT{1'b0}}});
	assign diff   = DIFF_W'(meas_scaled) - DIFF_W'(filt_q) + DIFF_W'(ERR_ROUND);
	assign e_full = diff[DIFF_W-1:ERR_SHIFT];
	assign err_next = (e_full > EF_MAX) ? EF_MAX[ERR_W-1:0] :
		(e_full < EF_MIN) ? EF_MIN[ERR_W-1:0] : e_full[ERR_W-1:0];

	// smoothed value limit check and magnitude for the divider
	assign v_over  = (acc > LIM);
	assign v_under = (acc < -LIM);
	assign v_abs   = acc[ACC_W-1] ? -acc : acc;

	// result drive value
	assign quo_ext    = $signed(DRIVE_W'(quo));
	assign drive_next = over_q ? DRV_LIM : under_q ? -DRV_LIM : neg_q ? -quo_ext : quo_ext;
	assign out_free   = !out_vld_q || !out_stall;

	// sequencer decode: shared multiplier operands and unit strobes
	always_comb begin
		mac_cmd   = '0;
		mul_a     = '0;
		mul_b     = '0;
		ring_cmd  = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_FILT_A: begin
				mac_cmd = '{issue: 1'b1, first: 1'b1};
				mul_a   = MUL_A_W'(targ_scaled);
				mul_b   = MUL_B_W'(FILT_TAKE);
			end
			ST_FILT_B: begin
				mac_cmd = '{issue: 1'b1, first: 1'b0};
				mul_a   = MUL_A_W'(filt_q);
				mul_b   = MUL_B_W'(FILT_KEEP);
			end
			ST_RING: begin
				ring_cmd = '{upd: 1'b1, clr: item_q.clear_history};
				mac_cmd  = '{issue: 1'b1, first: 1'b1};
				mul_a    = MUL_A_W'(err_q);
				mul_b    = $signed({1'b0, prop_q});
			end
			ST_OUT_B: begin
				mac_cmd = '{issue: 1'b1, first: 1'b0};
				mul_a   = MUL_A_W'(ring_sum);
				mul_b   = $signed({1'b0, igain_q});
			end
			ST_TICK_A: begin
				mac_cmd = '{issue: 1'b1, first: 1'b1};
				mul_a   = old_q;
				mul_b   = $signed(MUL_B_W'(coef_old));
			end
			ST_TICK_B: begin
				mac_cmd = '{issue: 1'b1, first: 1'b0};
				mul_a   = new_q;
				mul_b   = $signed(MUL_B_W'(coef_new));
			end
			ST_TICK_DONE: begin
				div_start = !(v_over || v_under);
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	// sequencer state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			filt_q    <= '0;
			new_q     <= '0;
			old_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// taken result transaction leaves, unless a new one is loaded this cycle
			if (out_vld_q && !out_stall && state_q != ST_EMIT) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= (in_item.operation == OP_TICK) ? ST_TICK_A : ST_FILT_A;
					end
				end
				ST_FILT_A:    state_q <= ST_FILT_B;
				ST_FILT_B:    state_q <= ST_FILT_W;
				ST_FILT_W:    state_q <= ST_FILT_DONE;
				ST_FILT_DONE: begin
					filt_q  <= filt_next;
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= err_next;
					state_q <= ST_RING;
				end
				ST_RING:  state_q <= ST_OUT_B;
				ST_OUT_B: state_q <= ST_OUT_W;
				ST_OUT_W: state_q <= ST_OUT_DONE;
				ST_OUT_DONE: begin
					old_q   <= new_q;
					new_q   <= acc[OUTV_W-1:0];
					state_q <= ST_IDLE;
				end
				ST_TICK_A: state_q <= ST_TICK_B;
				ST_TICK_B: state_q <= ST_TICK_W;
				ST_TICK_W: state_q <= ST_TICK_DONE;
				ST_TICK_DONE: begin
					over_q  <= v_over;
					under_q <= v_under;
					neg_q   <= acc[ACC_W-1];
					state_q <= (v_over || v_under) ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q     <= '{drive: drive_next, saturated: over_q || under_q};
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
			endcase
		end
	end

	spwc_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (mul_a),
		.b      (mul_b),
		.acc    (acc)
	);

	spwc_ring #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ring_cmd),
		.err    (err_q),
		.sum    (ring_sum)
	);

	spwc_div #(
		.SMOOTH_STEPS (SMOOTH_STEPS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_abs[MAG_W-1:0]),
		.done     (div_done),
		.quotient (quo)
	);

endmodule

### design/spwc_checker.sv
// port-level checks of the speed pi window control block, bound to the top level
// depends on spwc_pkg and speed_pi_window_control_defines.svh
`include "speed_pi_window_control_defines.svh"

module spwc_checker import spwc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	localparam logic signed [DRIVE_W-1:0] LIM_P = DRIVE_W'(DRIVE_LIMIT);
	localparam logic signed [DRIVE_W-1:0] LIM_N = -LIM_P;

	// a held result transaction keeps its payload
	`SPWC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

	// drive never leaves the motor limit
	`SPWC_ASSERT_IMPLY(a_drive_range, clk, arst_n, out_valid, out_item.drive <= LIM_P && out_item.drive >= LIM_N, "drive out of range")

	// a clipped result sits exactly on the limit
	`SPWC_ASSERT_IMPLY(a_sat_at_limit, clk, arst_n, out_valid && out_item.saturated, out_item.drive == LIM_P || out_item.drive == LIM_N, "saturated drive not at limit")

	// an accepted transaction makes the block stall its input in the next cycle
	`SPWC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "input taken on consecutive cycles")

endmodule

bind speed_pi_window_control spwc_checker u_spwc_checker (.*);

### tb/speed_pi_window_control_test.sv
// self-checking testbench for the speed pi window control block
// depends on spwc_pkg and speed_pi_window_control; driver, monitor and predictor in one module
`timescale 1ns / 1ps

module speed_pi_window_control_test;
	import spwc_pkg::*;

	localparam int WINDOW       = WINDOW_LEN_DEF;
	localparam int STEPS        = SMOOTH_STEPS_DEF;
	localparam int HALF_PERIOD  = 6;
	localparam int SETTLE_WAIT  = 40;
	localparam int QUIET_LIMIT  = 4000;
	localparam int STALL_BURST  = 300;
	localparam int PHASE_ITEMS  = 360;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROP_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expected results
	in_item_t  pending_items[$];
	out_item_t drive_expected[$];
	logic      in_accepted = 1'b0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        burst_requests = 0;
	int        burst_served = 0;
	int        burst_left = 0;
	int        quiet_cycles = 0;

	// run statistics
	int mismatches = 0;
	int n_controls = 0;
	int n_clears = 0;
	int n_ticks = 0;
	int n_clipped = 0;
	int n_settings = 0;

	// predictor state
	longint gain_p = longint'(PROP_GAIN_RST);
	longint gain_i = longint'(INTEGRAL_GAIN_RST);
	longint filt_target = 0;
	longint err_hist [WINDOW] = '{default: 0};
	int     hist_ptr = 0;
	longint hist_sum = 0;
	longint drive_new = 0;
	longint drive_old = 0;

	speed_pi_window_control #(
		.WINDOW_LEN  (WINDOW),
		.SMOOTH_STEPS(STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	always #(HALF_PERIOD) clk = ~clk;

	// control step: filter target, form error, update window, new controller output
	function automatic void control_update(input in_item_t it);
		longint meas;
		longint targ;
		longint err;
		meas = longint'(it.measured_speed);
		targ = longint'(it.target_speed);
		filt_target = (FILT_TAKE * targ * (longint'(1) << ERR_SHIFT) + FILT_KEEP * filt_target
			+ (longint'(1) << (FILT_SHIFT - 1))) >>> FILT_SHIFT;
		err = (meas * (longint'(1) << ERR_SHIFT) - filt_target
			+ (longint'(1) << (ERR_SHIFT - 1))) >>> ERR_SHIFT;
		if (err > 4095)
			err = 4095;
		if (err < -4096)
			err = -4096;
		if (it.clear_history) begin
			foreach (err_hist[i])
				err_hist[i] = 0;
			hist_sum = 0;
		end
		hist_sum = hist_sum - err_hist[hist_ptr] + err;
		err_hist[hist_ptr] = err;
		hist_ptr = (hist_ptr + 1 == WINDOW) ? 0 : hist_ptr + 1;
		drive_old = drive_new;
		drive_new = gain_p * err + gain_i * hist_sum;
	endfunction

	// smoothing tick: interpolate between old and new output, clip to the drive limit
	function automatic out_item_t smooth_drive(input logic [SLOT_W-1:0] slot);
		longint k;
		longint v;
		longint lim;
		out_item_t r;
		k = longint'(slot);
		if (k >= STEPS)
			k = STEPS - 1;
		v = drive_old * STEPS + (drive_new - drive_old) * (k + 1);
		lim = longint'(DRIVE_LIMIT) * STEPS * DRIVE_SCALE;
		if (v > lim) begin
			r.drive = DRIVE_W'(DRIVE_LIMIT);
			r.saturated = 1'b1;
		end else if (v < -lim) begin
			r.drive = DRIVE_W'(-DRIVE_LIMIT);
			r.saturated = 1'b1;
		end else begin
			r.drive = DRIVE_W'(v / (longint'(STEPS) * DRIVE_SCALE));
			r.saturated = 1'b0;
		end
		return r;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		return it;
	endfunction

	function automatic in_item_t make_control(input int meas, input int targ, input logic clr);
		in_item_t it;
		it = noise_item();
		it.operation = OP_CONTROL;
		it.measured_speed = SPEED_W'(meas);
		it.target_speed = SPEED_W'(targ);
		it.clear_history = clr;
		return it;
	endfunction

	function automatic in_item_t make_tick(input int slot);
		in_item_t it;
		it = noise_item();
		it.operation = OP_TICK;
		it.slot_index = SLOT_W'(slot);
		return it;
	endfunction

	// random speed, either anywhere in range or near a given value
	function automatic int pick_speed(input int near, input bit close);
		int s;
		if (close)
			s = near + $urandom_range(100) - 50;
		else
			s = $urandom_range(4095) - 2048;
		if (s > 2047)
			s = 2047;
		if (s < -2048)
			s = -2048;
		return s;
	endfunction

	// driver: offer the next pending item, hold it until accepted
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_accepted)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_item <= noise_item();
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (burst_served != burst_requests) begin
			burst_served = burst_requests;
			burst_left = STALL_BURST;
		end
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: check results, track register writes, predict accepted transactions
	always @(posedge clk) begin
		in_accepted <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_expected.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: expected none, got drive %0d sat %0b",
					$time, out_item.drive, out_item.saturated);
			end else begin
				out_item_t want;
				want = drive_expected.pop_front();
				if (out_item.drive !== want.drive) begin
					mismatches++;
					$display("%0t drive mismatch: expected %0d, got %0d",
						$time, want.drive, out_item.drive);
				end
				if (out_item.saturated !== want.saturated) begin
					mismatches++;
					$display("%0t saturated mismatch: expected %0b, got %0b",
						$time, want.saturated, out_item.saturated);
				end
				if (want.saturated)
					n_clipped++;
			end
		end
		if (cfg_we) begin
			if (cfg_index == CFG_PROP_GAIN)
				gain_p = longint'(cfg_data);
			else if (cfg_index == CFG_INTEGRAL_GAIN)
				gain_i = longint'(cfg_data);
		end
		if (arst_n && in_valid && !in_stall) begin
			if (in_item.operation == OP_CONTROL) begin
				control_update(in_item);
				n_controls++;
				if (in_item.clear_history)
					n_clears++;
			end else begin
				drive_expected.push_back(smooth_drive(in_item.slot_index));
				n_ticks++;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, drive_expected.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_gains(input int p, input int i);
		write_reg(CFG_PROP_GAIN, CFG_DATA_W'(p));
		write_reg(CFG_INTEGRAL_GAIN, CFG_DATA_W'(i));
		n_settings++;
	endtask

	// wait until all items are in and all results out, then let the block finish
	task automatic settle();
		while (pending_items.size() != 0 || in_valid || drive_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	// control periods with random content, plus some noise transactions
	task automatic queue_random_items(input int count);
		int n;
		int ticks;
		int start;
		int targ;
		bit scramble;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 85) begin
				targ = pick_speed(0, 1'b0);
				pending_items.push_back(make_control(pick_speed(targ, $urandom_range(1)), targ,
					$urandom_range(9) == 0));
				ticks = $urandom_range(STEPS, 1);
				start = $urandom_range(STEPS - ticks);
				scramble = ($urandom_range(4) == 0);
				for (int t = 0; t < ticks; t++)
					pending_items.push_back(make_tick(scramble ? $urandom_range(15) : start + t));
				n += ticks + 1;
			end else begin
				pending_items.push_back(noise_item());
				n++;
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset gains, full-scale errors, slot limits, clears
		send_idle_pct = 28;
		recv_idle_pct = 60;
		pending_items.push_back(make_tick(0));
		repeat (5) pending_items.push_back(make_control(2047, -2048, 1'b0));
		pending_items.push_back(make_tick(0));
		pending_items.push_back(make_tick(STEPS - 1));
		pending_items.push_back(make_tick(STEPS));
		pending_items.push_back(make_tick(15));
		repeat (5) pending_items.push_back(make_control(-2048, 2047, 1'b1));
		pending_items.push_back(make_tick(4));
		pending_items.push_back(make_tick(STEPS - 1));
		pending_items.push_back(make_control(0, 0, 1'b1));
		pending_items.push_back(make_tick(STEPS - 1));
		pending_items.push_back(make_control(5, 5, 1'b0));
		pending_items.push_back(make_tick(3));
		settle();

		// largest gains
		set_gains(65535, 65535);
		queue_random_items(PHASE_ITEMS);
		settle();

		// zero gains, idling swapped
		send_idle_pct = 60;
		recv_idle_pct = 28;
		set_gains(0, 0);
		queue_random_items(PHASE_ITEMS);
		settle();

		// moderate gains with a long receiver hold-off
		set_gains($urandom_range(600), $urandom_range(40));
		queue_random_items(PHASE_ITEMS);
		repeat (30) @(posedge clk);
		burst_requests++;
		settle();

		// no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_gains($urandom_range(65535), $urandom_range(65535));
		queue_random_items(PHASE_ITEMS);
		settle();

		set_gains(384, 8);
		queue_random_items(PHASE_ITEMS);
		settle();

		$display("covered %0d control steps (%0d with history clear), %0d smoothing ticks",
			n_controls, n_clears, n_ticks);
		$display("%0d clipped results over %0d gain settings, %0d mismatches",
			n_clipped, n_settings, mismatches);
		if (mismatches == 0 && drive_expected.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
